FILE: sv/tcts_pkg.sv
package tcts_pkg;

  localparam int MAX_CUES_DEF = 32;
  localparam int CNT_W        = 6;
  localparam int IDX_W        = 5;
  localparam int ID_W         = 16;
  localparam int GRP_W        = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int TIME_W       = 64;
  localparam int START_W      = 32;
  localparam int GWORD_W      = 16;
  localparam int MASK_BITS    = 12;
  localparam logic [11:0] VALUE_MASK = 12'h0FFF;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_TICK  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    OP_NONE     = 2'd0,
    OP_FILL     = 2'd1,
    OP_BLACKOUT = 2'd2
  } led_op_e;

  localparam logic [2:0] KIND_STOP     = 3'd0;
  localparam logic [2:0] KIND_FILL     = 3'd1;
  localparam logic [2:0] KIND_BLACKOUT = 3'd2;

  localparam logic [3:0] MODE_ALL       = 4'd0;
  localparam logic [3:0] MODE_ID        = 4'd1;
  localparam logic [3:0] MODE_GROUP     = 4'd2;
  localparam logic [3:0] MODE_MASK      = 4'd3;
  localparam logic [3:0] MODE_NOT_ID    = 4'd4;
  localparam logic [3:0] MODE_NOT_GROUP = 4'd5;
  localparam logic [3:0] MODE_NOT_MASK  = 4'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_CUE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONE_ID    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONE_GROUP = 2'd2;

  typedef struct packed {
    logic [START_W-1:0] cue_time;
    logic [GWORD_W-1:0] group_word;
    logic [2:0]         kind;
    logic [7:0]         channel;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } cue_entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [1:0]       op;
    logic [2:0]       channel;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } cue_result_t;

  function automatic logic targets_me(input logic [GWORD_W-1:0] word,
                                      input logic [ID_W-1:0]    id,
                                      input logic [GRP_W-1:0]   grp);
    logic [3:0]  mode;
    logic [11:0] value;
    logic        in_mask;
    logic        hit;
    mode    = word[15:12];
    value   = word[11:0] & VALUE_MASK;
    in_mask = 1'b0;
    if (grp < GRP_W'(MASK_BITS)) begin
      in_mask = value[grp[3:0]];
    end
    case (mode)
      MODE_ALL:       hit = 1'b1;
      MODE_ID:        hit = (id == {4'b0, value});
      MODE_GROUP:     hit = ({4'b0, grp} == value);
      MODE_MASK:      hit = in_mask;
      MODE_NOT_ID:    hit = (id != {4'b0, value});
      MODE_NOT_GROUP: hit = ({4'b0, grp} != value);
      MODE_NOT_MASK:  hit = !in_mask;
      default:        hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic cue_result_t make_result(input logic [IDX_W-1:0] idx,
                                              input cue_entry_t       e);
    cue_result_t r;
    r       = '0;
    r.index = idx;
    if ((e.kind == KIND_STOP || e.kind == KIND_FILL) &&
        e.channel >= 8'd1 && e.channel <= 8'd4) begin
      r.op      = OP_FILL;
      r.channel = e.channel[2:0];
      if (e.kind == KIND_FILL) begin
        r.red   = e.red;
        r.green = e.green;
        r.blue  = e.blue;
      end
    end else if (e.kind == KIND_BLACKOUT) begin
      r.op = OP_BLACKOUT;
    end
    return r;
  endfunction

endpackage

FILE: sv/tcts_table.sv
module tcts_table #(
  parameter int DEPTH = tcts_pkg::MAX_CUES_DEF,
  parameter int AW    = 5
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  tcts_pkg::cue_entry_t wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output tcts_pkg::cue_entry_t rd_data_o
);
  import tcts_pkg::*;

  cue_entry_t mem_q [DEPTH];
  cue_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/timed_cue_table_scheduler.sv
// Timed cue scheduler. Every input word yields zero or more cue results followed by one
// closing result with last_o set. A tick while playing with a nonzero time scans the
// active entries of the cue table, one entry per cycle through the table RAM read port;
// the fired cues that target this unit are collected in a result RAM and then delivered
// one by one, each read through the states S_DR_ADDR, S_DR_LOAD and S_DR_WAIT, followed
// by the closing word, so that every result already carries the final playing flag
// and fired count. New input is stalled until the closing result has been taken.
module timed_cue_table_scheduler #(
  parameter int MAX_CUES = tcts_pkg::MAX_CUES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tcts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tcts_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       action_i,
  input  logic [tcts_pkg::IDX_W-1:0]       entry_index_i,
  input  logic [tcts_pkg::START_W-1:0]     cue_start_ms_i,
  input  logic [tcts_pkg::GWORD_W-1:0]     group_word_i,
  input  logic [2:0]                       cue_kind_i,
  input  logic [7:0]                       led_channel_in_i,
  input  logic [7:0]                       red_in_i,
  input  logic [7:0]                       green_in_i,
  input  logic [7:0]                       blue_in_i,
  input  logic [tcts_pkg::TIME_W-1:0]      time_ms_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             valid_res_o,
  output logic [tcts_pkg::IDX_W-1:0]       cue_index_o,
  output logic [1:0]                       led_op_o,
  output logic [2:0]                       led_channel_out_o,
  output logic [7:0]                       red_out_o,
  output logic [7:0]                       green_out_o,
  output logic [7:0]                       blue_out_o,
  output logic                             playing_now_o,
  output logic [tcts_pkg::CNT_W-1:0]       fired_total_out_o,
  output logic                             last_o
);
  import tcts_pkg::*;

  localparam int AW = (MAX_CUES > 1) ? $clog2(MAX_CUES) : 1;
  localparam int SW = $clog2(MAX_CUES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DR_ADDR,
    S_DR_LOAD,
    S_DR_WAIT,
    S_CLOSE,
    S_CL_WAIT
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    cue_count_q;
  logic [ID_W-1:0]     cone_id_q;
  logic [GRP_W-1:0]    cone_group_q;
  logic [MAX_CUES-1:0] fired_q;
  logic                playing_q;
  logic [CNT_W-1:0]    fired_total_q;
  logic [TIME_W-1:0]   music_start_q;
  logic [TIME_W-1:0]   elapsed_q;
  logic [SW-1:0]       sc_q;
  logic [SW-1:0]       rc_q;
  logic [SW-1:0]       rp_q;
  logic                pv_q;
  logic [AW-1:0]       pidx_q;
  logic                out_valid_q;
  logic                out_vres_q;
  logic                out_last_q;
  cue_result_t         out_res_q;
  cue_result_t         res_mem_q [MAX_CUES];
  cue_result_t         res_rd_q;

  logic        in_acc;
  logic        load_ok;
  logic [CNT_W-1:0] active_cnt;
  logic        issue;
  logic        due;
  logic        fire;
  logic        hit;
  cue_entry_t  tab_wdata;
  cue_entry_t  tab_rdata;
  cue_result_t res_wdata;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign load_ok     = ({1'b0, entry_index_i} < CNT_W'(MAX_CUES));
  assign active_cnt  = (cue_count_q > CNT_W'(MAX_CUES)) ? CNT_W'(MAX_CUES) : cue_count_q;
  assign issue       = (state_q == S_SCAN) && (CNT_W'(sc_q) < active_cnt);

  assign tab_wdata = '{cue_time: cue_start_ms_i, group_word: group_word_i,
                       kind: cue_kind_i, channel: led_channel_in_i,
                       red: red_in_i, green: green_in_i, blue: blue_in_i};

  tcts_table #(
    .DEPTH (MAX_CUES),
    .AW    (AW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc && action_e'(action_i) == ACT_LOAD && load_ok),
    .wr_addr_i (AW'(entry_index_i)),
    .wr_data_i (tab_wdata),
    .rd_en_i   (issue),
    .rd_addr_i (sc_q[AW-1:0]),
    .rd_data_o (tab_rdata)
  );

  assign due = (elapsed_q[TIME_W-1:START_W] != '0) ||
               (tab_rdata.cue_time <= elapsed_q[START_W-1:0]);
  assign fire = pv_q && !fired_q[pidx_q] && due;
  assign hit  = fire && targets_me(tab_rdata.group_word, cone_id_q, cone_group_q);
  assign res_wdata = make_result(IDX_W'(pidx_q), tab_rdata);

  always_ff @(posedge clk_i) begin
    if (hit) begin
      res_mem_q[rc_q[AW-1:0]] <= res_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DR_ADDR) begin
      res_rd_q <= res_mem_q[rp_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cue_count_q  <= '0;
      cone_id_q    <= '0;
      cone_group_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CUE_COUNT:  cue_count_q  <= cfg_data_i[CNT_W-1:0];
        CFG_CONE_ID:    cone_id_q    <= cfg_data_i[ID_W-1:0];
        CFG_CONE_GROUP: cone_group_q <= cfg_data_i[GRP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      fired_q       <= '0;
      playing_q     <= 1'b0;
      fired_total_q <= '0;
      music_start_q <= '0;
      elapsed_q     <= '0;
      sc_q          <= '0;
      rc_q          <= '0;
      rp_q          <= '0;
      pv_q          <= 1'b0;
      pidx_q        <= '0;
      out_valid_q   <= 1'b0;
      out_vres_q    <= 1'b0;
      out_last_q    <= 1'b0;
      out_res_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_CLOSE;
            case (action_e'(action_i))
              ACT_LOAD: begin
                if (load_ok) begin
                  fired_q[AW'(entry_index_i)] <= 1'b0;
                end
                fired_total_q <= '0;
                playing_q     <= 1'b0;
              end
              ACT_START: begin
                if (active_cnt != '0) begin
                  music_start_q <= time_ms_i;
                  fired_total_q <= '0;
                  fired_q       <= '0;
                  playing_q     <= 1'b1;
                end
              end
              ACT_STOP: begin
                playing_q <= 1'b0;
              end
              ACT_TICK: begin
                if (playing_q && time_ms_i != '0) begin
                  elapsed_q <= (time_ms_i > music_start_q) ? time_ms_i - music_start_q : '0;
                  sc_q      <= '0;
                  rc_q      <= '0;
                  pv_q      <= 1'b0;
                  state_q   <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            sc_q   <= sc_q + 1'b1;
            pidx_q <= sc_q[AW-1:0];
            pv_q   <= 1'b1;
          end else begin
            pv_q <= 1'b0;
          end
          if (fire) begin
            fired_q[pidx_q] <= 1'b1;
            fired_total_q   <= fired_total_q + 1'b1;
          end
          if (hit) begin
            rc_q <= rc_q + 1'b1;
          end
          if (!issue && !pv_q) begin
            if (fired_total_q >= active_cnt) begin
              playing_q <= 1'b0;
            end
            rp_q    <= '0;
            state_q <= (rc_q == '0) ? S_CLOSE : S_DR_ADDR;
          end
        end
        S_DR_ADDR: begin
          state_q <= S_DR_LOAD;
        end
        S_DR_LOAD: begin
          out_res_q   <= res_rd_q;
          out_vres_q  <= 1'b1;
          out_last_q  <= 1'b0;
          out_valid_q <= 1'b1;
          state_q     <= S_DR_WAIT;
        end
        S_DR_WAIT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            rp_q        <= rp_q + 1'b1;
            state_q     <= (rp_q + 1'b1 == rc_q) ? S_CLOSE : S_DR_ADDR;
          end
        end
        S_CLOSE: begin
          out_res_q   <= '0;
          out_vres_q  <= 1'b0;
          out_last_q  <= 1'b1;
          out_valid_q <= 1'b1;
          state_q     <= S_CL_WAIT;
        end
        S_CL_WAIT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign valid_res_o       = out_vres_q;
  assign cue_index_o       = out_res_q.index;
  assign led_op_o          = out_res_q.op;
  assign led_channel_out_o = out_res_q.channel;
  assign red_out_o         = out_res_q.red;
  assign green_out_o       = out_res_q.green;
  assign blue_out_o        = out_res_q.blue;
  assign playing_now_o     = playing_q;
  assign fired_total_out_o = fired_total_q;
  assign last_o            = out_last_q;

endmodule

FILE: sv/tcts_checker.sv
module tcts_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       valid_res_o,
  input logic                       last_o,
  input logic [1:0]                 led_op_o,
  input logic [2:0]                 led_channel_out_o,
  input logic [tcts_pkg::IDX_W-1:0] cue_index_o
);
  import tcts_pkg::*;

  // A result word is only presented while the input side is held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("output word presented while input is open");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not held off after an accepted word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (valid_res_o != last_o))
    else $error("cue result and closing flag disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && led_op_o == OP_FILL) |->
      (led_channel_out_o != 3'd0 && led_channel_out_o <= 3'd4))
    else $error("fill result with a channel outside one to four");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(cue_index_o) && $stable(last_o)))
    else $error("stalled output word changed");

endmodule

bind timed_cue_table_scheduler tcts_checker u_tcts_checker (.*);

FILE: verif/tb_timed_cue_table_scheduler.sv
module tb_timed_cue_table_scheduler;
  import tcts_pkg::*;

  localparam int NCUE           = MAX_CUES_DEF;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    action_e      action;
    logic [4:0]   entry_index;
    logic [31:0]  cue_time;
    logic [15:0]  group_word;
    logic [2:0]   kind;
    logic [7:0]   channel;
    logic [7:0]   red;
    logic [7:0]   green;
    logic [7:0]   blue;
    logic [63:0]  time_ms;
  } cue_word_t;

  typedef struct packed {
    logic         valid_res;
    logic [4:0]   index;
    logic [1:0]   op;
    logic [2:0]   channel;
    logic [7:0]   red;
    logic [7:0]   green;
    logic [7:0]   blue;
    logic         playing;
    logic [5:0]   fired_total;
    logic         closing;
  } cue_outcome_t;

  class cue_scoreboard;
    logic [31:0]  due_ms [NCUE];
    logic [15:0]  aim [NCUE];
    logic [2:0]   kind [NCUE];
    logic [7:0]   chan [NCUE];
    logic [7:0]   red [NCUE];
    logic [7:0]   grn [NCUE];
    logic [7:0]   blu [NCUE];
    bit           fired [NCUE];
    bit           loaded [NCUE];
    bit           playing;
    logic [5:0]   n_fired;
    logic [63:0]  epoch;
    logic [5:0]   count_reg;
    logic [15:0]  unit_id;
    logic [7:0]   unit_group;
    cue_outcome_t due_results[$];
    int           errors;

    function new();
      playing    = 1'b0;
      n_fired    = '0;
      epoch      = '0;
      count_reg  = '0;
      unit_id    = '0;
      unit_group = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CUE_COUNT:  count_reg = data[5:0];
        CFG_CONE_ID:    unit_id = data;
        CFG_CONE_GROUP: unit_group = data[7:0];
        default: ;
      endcase
    endfunction

    function int live_count();
      return (count_reg > NCUE) ? NCUE : int'(count_reg);
    endfunction

    function bit aimed_here(logic [15:0] w);
      logic [11:0] val;
      bit          in_set;
      val    = w[11:0];
      in_set = (unit_group < 12) && val[unit_group[3:0]];
      case (w[15:12])
        MODE_ALL:       return 1'b1;
        MODE_ID:        return unit_id == {4'b0, val};
        MODE_GROUP:     return {4'b0, unit_group} == val;
        MODE_MASK:      return in_set;
        MODE_NOT_ID:    return unit_id != {4'b0, val};
        MODE_NOT_GROUP: return {4'b0, unit_group} != val;
        MODE_NOT_MASK:  return !in_set;
        default:        return 1'b0;
      endcase
    endfunction

    function bit note_input(cue_word_t w);
      cue_outcome_t r;
      cue_outcome_t batch[$];
      logic [63:0]  elapsed;
      int           cnt;
      bit           effective;
      effective = 1'b1;
      case (w.action)
        ACT_LOAD: begin
          due_ms[w.entry_index] = w.cue_time;
          aim[w.entry_index]    = w.group_word;
          kind[w.entry_index]   = w.kind;
          chan[w.entry_index]   = w.channel;
          red[w.entry_index]    = w.red;
          grn[w.entry_index]    = w.green;
          blu[w.entry_index]    = w.blue;
          fired[w.entry_index]  = 1'b0;
          loaded[w.entry_index] = 1'b1;
          n_fired = '0;
          playing = 1'b0;
        end
        ACT_START: begin
          if (live_count() != 0) begin
            epoch   = w.time_ms;
            n_fired = '0;
            foreach (fired[i]) fired[i] = 1'b0;
            playing = 1'b1;
          end else begin
            effective = 1'b0;
          end
        end
        ACT_STOP: playing = 1'b0;
        default: begin
          if (playing && w.time_ms != 0) begin
            elapsed = (w.time_ms > epoch) ? w.time_ms - epoch : '0;
            cnt     = live_count();
            for (int i = 0; i < cnt; i++) begin
              if (!fired[i] && {32'b0, due_ms[i]} <= elapsed) begin
                if (aimed_here(aim[i])) begin
                  r           = '0;
                  r.valid_res = 1'b1;
                  r.index     = i[4:0];
                  if ((kind[i] == KIND_STOP || kind[i] == KIND_FILL) &&
                      chan[i] >= 8'd1 && chan[i] <= 8'd4) begin
                    r.op      = OP_FILL;
                    r.channel = chan[i][2:0];
                    if (kind[i] == KIND_FILL) begin
                      r.red   = red[i];
                      r.green = grn[i];
                      r.blue  = blu[i];
                    end
                  end else if (kind[i] == KIND_BLACKOUT) begin
                    r.op = OP_BLACKOUT;
                  end
                  batch.push_back(r);
                end
                fired[i] = 1'b1;
                n_fired++;
              end
            end
            if (n_fired >= cnt) playing = 1'b0;
          end else begin
            effective = 1'b0;
          end
        end
      endcase
      r         = '0;
      r.closing = 1'b1;
      batch.push_back(r);
      foreach (batch[k]) begin
        batch[k].playing     = playing;
        batch[k].fired_total = n_fired;
        due_results.push_back(batch[k]);
      end
      return effective;
    endfunction

    function void compare_field(string name, logic [63:0] e, logic [63:0] g);
      if (g !== e) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, e, g);
        errors++;
      end
    endfunction

    function void check_result(cue_outcome_t got);
      cue_outcome_t e;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result word, got %p", $time, got);
        errors++;
        return;
      end
      e = due_results.pop_front();
      compare_field("valid_res", e.valid_res, got.valid_res);
      compare_field("cue_index", e.index, got.index);
      compare_field("led_op", e.op, got.op);
      compare_field("led_channel_out", e.channel, got.channel);
      compare_field("red_out", e.red, got.red);
      compare_field("green_out", e.green, got.green);
      compare_field("blue_out", e.blue, got.blue);
      compare_field("playing_now", e.playing, got.playing);
      compare_field("fired_total_out", e.fired_total, got.fired_total);
      compare_field("last", e.closing, got.closing);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [1:0]            action_i;
  logic [IDX_W-1:0]      entry_index_i;
  logic [START_W-1:0]    cue_start_ms_i;
  logic [GWORD_W-1:0]    group_word_i;
  logic [2:0]            cue_kind_i;
  logic [7:0]            led_channel_in_i;
  logic [7:0]            red_in_i;
  logic [7:0]            green_in_i;
  logic [7:0]            blue_in_i;
  logic [TIME_W-1:0]     time_ms_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  valid_res_o;
  logic [IDX_W-1:0]      cue_index_o;
  logic [1:0]            led_op_o;
  logic [2:0]            led_channel_out_o;
  logic [7:0]            red_out_o;
  logic [7:0]            green_out_o;
  logic [7:0]            blue_out_o;
  logic                  playing_now_o;
  logic [CNT_W-1:0]      fired_total_out_o;
  logic                  last_o;

  cue_scoreboard sb;
  int            rx_hold_cycles;
  int            random_credit;
  bit            rx_idle_en;
  bit            tx_idle_en;

  timed_cue_table_scheduler i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .entry_index_i     (entry_index_i),
    .cue_start_ms_i    (cue_start_ms_i),
    .group_word_i      (group_word_i),
    .cue_kind_i        (cue_kind_i),
    .led_channel_in_i  (led_channel_in_i),
    .red_in_i          (red_in_i),
    .green_in_i        (green_in_i),
    .blue_in_i         (blue_in_i),
    .time_ms_i         (time_ms_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .valid_res_o       (valid_res_o),
    .cue_index_o       (cue_index_o),
    .led_op_o          (led_op_o),
    .led_channel_out_o (led_channel_out_o),
    .red_out_o         (red_out_o),
    .green_out_o       (green_out_o),
    .blue_out_o        (blue_out_o),
    .playing_now_o     (playing_now_o),
    .fired_total_out_o (fired_total_out_o),
    .last_o            (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [15:0] pick_aim();
    logic [3:0]  mode;
    logic [11:0] val;
    mode = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(7, 15)) : 4'($urandom_range(0, 6));
    case ($urandom_range(0, 3))
      0: val = sb.unit_id[11:0];
      1: val = 12'(sb.unit_group);
      2: val = (sb.unit_group < 12) ? 12'(1) << sb.unit_group : 12'($urandom);
      default: val = 12'($urandom);
    endcase
    return {mode, val};
  endfunction

  function automatic cue_word_t noise_word();
    cue_word_t w;
    w.action      = action_e'($urandom_range(0, 3));
    w.entry_index = 5'($urandom);
    w.cue_time    = $urandom;
    w.group_word  = 16'($urandom);
    w.kind        = 3'($urandom);
    w.channel     = 8'($urandom);
    w.red         = 8'($urandom);
    w.green       = 8'($urandom);
    w.blue        = 8'($urandom);
    w.time_ms     = ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom};
    return w;
  endfunction

  function automatic cue_word_t timed_word(action_e a, logic [63:0] t);
    cue_word_t w;
    w         = noise_word();
    w.action  = a;
    w.time_ms = t;
    return w;
  endfunction

  function automatic cue_word_t make_load(int idx, logic [31:0] st, logic [15:0] gw,
                                          logic [2:0] k, logic [7:0] ch, logic [7:0] r,
                                          logic [7:0] g, logic [7:0] b);
    cue_word_t w;
    w             = noise_word();
    w.action      = ACT_LOAD;
    w.entry_index = idx[4:0];
    w.cue_time    = st;
    w.group_word  = gw;
    w.kind        = k;
    w.channel     = ch;
    w.red         = r;
    w.green       = g;
    w.blue        = b;
    return w;
  endfunction

  function automatic cue_word_t load_word(int idx);
    logic [31:0] st;
    logic [2:0]  k;
    logic [7:0]  ch;
    case ($urandom_range(0, 9))
      0: st = $urandom;
      1: st = '1;
      default: st = $urandom_range(0, 600);
    endcase
    k  = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 2));
    ch = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4));
    return make_load(idx, st, pick_aim(), k, ch, 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic cue_word_t keep_legal(cue_word_t w);
    if (w.action == ACT_START || w.action == ACT_TICK) begin
      for (int i = 0; i < sb.live_count(); i++) begin
        if (!sb.loaded[i]) return load_word(i);
      end
    end
    return w;
  endfunction

  task automatic send_word(input cue_word_t w, output bit effective);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= w.action;
    entry_index_i    <= w.entry_index;
    cue_start_ms_i   <= w.cue_time;
    group_word_i     <= w.group_word;
    cue_kind_i       <= w.kind;
    led_channel_in_i <= w.channel;
    red_in_i         <= w.red;
    green_in_i       <= w.green;
    blue_in_i        <= w.blue;
    time_ms_i        <= w.time_ms;
    do @(posedge clk_i); while (in_stall_o);
    effective = sb.note_input(w);
  endtask

  task automatic put(input cue_word_t w);
    bit effective;
    send_word(w, effective);
  endtask

  task automatic offer(input cue_word_t w);
    bit effective;
    send_word(keep_legal(w), effective);
    if (effective) random_credit++;
  endtask

  task automatic configure(input int count, input int id, input int grp);
    logic [CFG_IDX_W-1:0]  idx  [3];
    logic [CFG_DATA_W-1:0] data [3];
    idx[0]  = CFG_CUE_COUNT;
    idx[1]  = CFG_CONE_ID;
    idx[2]  = CFG_CONE_GROUP;
    data[0] = {10'($urandom), 6'(count)};
    data[1] = 16'(id);
    data[2] = {8'($urandom), 8'(grp)};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= data[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(idx[i], data[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic play_show();
    int          cnt;
    logic [63:0] t0;
    logic [63:0] t;
    cnt = sb.live_count();
    for (int i = 0; i < cnt; i++) begin
      if (!sb.loaded[i] || $urandom_range(0, 2) == 0) offer(load_word(i));
    end
    if (cnt == 0 || $urandom_range(0, 3) == 0) offer(load_word($urandom_range(0, NCUE - 1)));
    t0 = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(1, 100000));
    offer(timed_word(ACT_START, t0));
    t = t0;
    repeat ($urandom_range(2, 6)) begin
      t = t + 64'($urandom_range(0, 300));
      case ($urandom_range(0, 9))
        0: offer(timed_word(ACT_TICK, 64'd0));
        1: offer(timed_word(ACT_TICK, t0 - 64'($urandom_range(1, 50))));
        2: offer(timed_word(ACT_STOP, t));
        default: offer(timed_word(ACT_TICK, t));
      endcase
    end
    if ($urandom_range(0, 1) == 0) offer(timed_word(ACT_TICK, t0 + 64'hFFFF_FFFF));
    else offer(timed_word(ACT_TICK, '1));
  endtask

  task automatic run_phase(input int count, input int id, input int grp, input int budget,
                           input bit idle);
    configure(count, id, grp);
    tx_idle_en    = idle;
    rx_idle_en    = idle;
    random_credit = 0;
    while (random_credit < budget) begin
      if ($urandom_range(0, 4) == 0) offer(noise_word());
      else play_show();
    end
    drain();
  endtask

  initial begin
    cue_outcome_t got;
    int           burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.valid_res   = valid_res_o;
        got.index       = cue_index_o;
        got.op          = led_op_o;
        got.channel     = led_channel_out_o;
        got.red         = red_out_o;
        got.green       = green_out_o;
        got.blue        = blue_out_o;
        got.playing     = playing_now_o;
        got.fired_total = fired_total_out_o;
        got.closing     = last_o;
        sb.check_result(got);
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_stall_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 9);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet);
        $display("tb_timed_cue_table_scheduler: done, errors");
        $finish;
      end
    end
  end

  initial begin
    sb               = new();
    rx_hold_cycles   = 0;
    rx_idle_en       = 1'b1;
    tx_idle_en       = 1'b1;
    rst_ni           <= 1'b0;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= '0;
    cfg_data_i       <= '0;
    in_valid_i       <= 1'b0;
    action_i         <= '0;
    entry_index_i    <= '0;
    cue_start_ms_i   <= '0;
    group_word_i     <= '0;
    cue_kind_i       <= '0;
    led_channel_in_i <= '0;
    red_in_i         <= '0;
    green_in_i       <= '0;
    blue_in_i        <= '0;
    time_ms_i        <= '0;
    out_stall_i      <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    put(timed_word(ACT_START, '1));
    put(timed_word(ACT_TICK, '1));
    put(timed_word(ACT_STOP, 64'd5));
    drain();
    configure(4, 16'h0123, 5);
    put(make_load(0, 32'd0, {MODE_ALL, 12'h000}, KIND_FILL, 8'd1, 8'hFF, 8'h00, 8'hAA));
    put(make_load(1, 32'd10, {MODE_ID, 12'h123}, KIND_STOP, 8'd4, 8'h11, 8'h22, 8'h33));
    put(make_load(2, 32'd10, {MODE_NOT_MASK, 12'h020}, KIND_BLACKOUT, 8'd2, 8'h01, 8'h02,
                  8'h03));
    put(make_load(3, '1, {MODE_GROUP, 12'h005}, 3'd3, 8'd2, 8'h44, 8'h55, 8'h66));
    put(timed_word(ACT_START, 64'd1000));
    put(timed_word(ACT_TICK, 64'd0));
    put(timed_word(ACT_TICK, 64'd500));
    drain();
    configure(1, 16'h0123, 5);
    put(timed_word(ACT_TICK, 64'd700));
    drain();
    configure(4, 16'h0123, 5);
    put(timed_word(ACT_START, 64'd1000));
    put(timed_word(ACT_TICK, 64'd1010));
    put(timed_word(ACT_TICK, '1));
    put(timed_word(ACT_TICK, 64'd2000));
    put(make_load(31, '1, '1, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    put(make_load(4, 32'd0, {MODE_MASK, 12'hFFF}, KIND_FILL, 8'd5, 8'h12, 8'h34, 8'h56));
    put(make_load(5, 32'd0, {MODE_NOT_ID, 12'h124}, KIND_FILL, 8'd2, 8'h9A, 8'hBC, 8'hDE));
    put(make_load(6, 32'd0, {MODE_NOT_GROUP, 12'h005}, KIND_FILL, 8'd3, 8'h77, 8'h88,
                  8'h99));
    put(make_load(7, 32'd0, {MODE_ALL, 12'hABC}, 3'd4, 8'd1, 8'h0F, 8'hF0, 8'h5A));
    drain();
    configure(8, 16'h0123, 5);
    put(timed_word(ACT_START, 64'd0));
    put(timed_word(ACT_TICK, 64'd1));
    put(timed_word(ACT_TICK, 64'h1_0000_0000));
    put(timed_word(ACT_STOP, 64'd0));
    drain();

    run_phase(3, $urandom_range(0, 65535), 0, 4, 1'b1);
    run_phase(32, 16'hFFFF, 11, 1, 1'b1);
    run_phase(63, 16'h0000, 12, 1, 1'b1);
    run_phase(1, 16'h0FFF, 255, 3, 1'b1);
    rx_hold_cycles = 300;
    run_phase(5, $urandom_range(0, 4095), $urandom_range(0, 11), 4, 1'b1);
    run_phase(0, $urandom_range(0, 65535), $urandom_range(0, 255), 1, 1'b1);
    run_phase(2, $urandom_range(0, 4095), $urandom_range(0, 15), 4, 1'b0);

    repeat (20) @(posedge clk_i);
    if (sb.due_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.due_results.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("tb_timed_cue_table_scheduler: done, clean");
    end else begin
      $display("tb_timed_cue_table_scheduler: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/tcts_pkg.sv
sv/tcts_table.sv
sv/timed_cue_table_scheduler.sv
sv/tcts_checker.sv
verif/tb_timed_cue_table_scheduler.sv
